// ===== hdl/hsv2rgb_pkg.sv =====
// Shared types and constants for the HSV to RGB color converter.
// No dependencies; imported by hsv_to_rgb_converter.
package hsv2rgb_pkg;

  // Fixed field widths of the ports
  localparam int unsigned InW  = 18;
  localparam int unsigned OutW = 17;

  // Default number of fractional bits (1.0 is 2**FracBits)
  localparam int unsigned FracBitsDefault = 16;

  // Hue sector, integer part of hue * 6; the wrap code covers hue of exactly one
  typedef enum logic [2:0] {
    SECT_RED_YEL = 3'd0,
    SECT_YEL_GRN = 3'd1,
    SECT_GRN_CYN = 3'd2,
    SECT_CYN_BLU = 3'd3,
    SECT_BLU_MAG = 3'd4,
    SECT_MAG_RED = 3'd5,
    SECT_WRAP    = 3'd6
  } sector_e;

endpackage

// ===== hdl/hsv_to_rgb_converter.sv =====
// Fixed-point HSV to RGB color converter, four register stages.
// Depends on hsv2rgb_pkg (widths, sector codes).
//
// Usage:
//   Input channel in_valid_i / in_ready_o carries hue_i, saturation_i and
//   brightness_i: signed 18-bit, FracBits fractional bits, each clamped to
//   0..1.0 internally. Output channel out_valid_o / out_ready_i carries
//   red_o, green_o and blue_o: unsigned 17-bit, same scaling.
//   Every input transaction yields exactly one output transaction, in order.
// Timing:
//   Throughput is one transaction per cycle while out_ready_i is high; the
//   stages are clamp and hue*6, the first multiplier rank (s*f, s*(1-f),
//   v*(1-s)), the second multiplier rank (v times the q and t factors), and
//   the sector mux into the output register.
// Reset:
//   rst_ni clears all stage valid bits; the pipeline comes up empty and ready.
// Stall:
//   When out_ready_i is low, the output holds and the stages behind it fill
//   bubbles first; in_ready_o drops only once every stage holds a transaction.
module hsv_to_rgb_converter #(
  parameter int unsigned FracBits = hsv2rgb_pkg::FracBitsDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [hsv2rgb_pkg::InW-1:0] hue_i,
  input  logic signed [hsv2rgb_pkg::InW-1:0] saturation_i,
  input  logic signed [hsv2rgb_pkg::InW-1:0] brightness_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic        [hsv2rgb_pkg::OutW-1:0] red_o,
  output logic        [hsv2rgb_pkg::OutW-1:0] green_o,
  output logic        [hsv2rgb_pkg::OutW-1:0] blue_o
);
  import hsv2rgb_pkg::*;

  // Value width holds 0..1.0; compare width also holds any positive input
  localparam int unsigned VW  = FracBits + 1;
  localparam int unsigned XW  = (VW > InW - 1) ? VW : InW - 1;
  localparam int unsigned H6W = VW + 3;
  localparam int unsigned EW  = (VW > OutW) ? VW : OutW;
  localparam logic [XW-1:0] OneX = XW'(1) << FracBits;
  localparam logic [VW-1:0] OneV = VW'(1) << FracBits;

  // Clamp a signed input to 0..1.0
  function automatic logic [VW-1:0] clamp_unit(input logic [InW-1:0] raw);
    logic [XW-1:0] x;
    logic [VW-1:0] res;
    x = XW'(raw[InW-2:0]);
    if (raw[InW-1]) begin
      res = '0;
    end else if (x > OneX) begin
      res = OneV;
    end else begin
      res = VW'(x);
    end
    return res;
  endfunction

  // Stage handshake: a stage loads when empty or when it drains this cycle
  logic v1_q, v2_q, v3_q, v4_q;
  logic adv1, adv2, adv3, adv4;

  assign adv4       = !v4_q || out_ready_i;
  assign adv3       = !v3_q || adv4;
  assign adv2       = !v2_q || adv3;
  assign adv1       = !v1_q || adv2;
  assign in_ready_o = adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_valid_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
      if (adv4) v4_q <= v3_q;
    end
  end

  // Stage 1: clamp inputs, form hue * 6 and split into sector and fraction
  logic [VW-1:0]       h_c, s_d, v_d;
  logic [H6W-1:0]      h6_c;
  sector_e             sect_d;
  logic [FracBits-1:0] frac_d;
  logic [VW-1:0]       s1_q, v1v_q;
  sector_e             sect1_q;
  logic [FracBits-1:0] frac1_q;

  always_comb begin
    h_c    = clamp_unit(hue_i);
    s_d    = clamp_unit(saturation_i);
    v_d    = clamp_unit(brightness_i);
    h6_c   = (H6W'(h_c) << 2) + (H6W'(h_c) << 1);
    sect_d = sector_e'(h6_c[FracBits+2:FracBits]);
    frac_d = h6_c[FracBits-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      s1_q    <= s_d;
      v1v_q   <= v_d;
      sect1_q <= sect_d;
      frac1_q <= frac_d;
    end
  end

  // Stage 2: s*f, s*(1-f) and p = v*(1-s), each truncated
  logic [VW+FracBits-1:0] sf_prod;
  logic [2*VW-1:0]        sfc_prod, p_prod;
  logic [VW-1:0]          one_m_f, one_m_s;
  logic [VW-1:0]          sf_q, sfc_q, p2_q, v2v_q;
  sector_e                sect2_q;

  always_comb begin
    one_m_f  = OneV - VW'(frac1_q);
    one_m_s  = OneV - s1_q;
    sf_prod  = (VW+FracBits)'(s1_q) * (VW+FracBits)'(frac1_q);
    sfc_prod = (2*VW)'(s1_q) * (2*VW)'(one_m_f);
    p_prod   = (2*VW)'(v1v_q) * (2*VW)'(one_m_s);
  end

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      sf_q    <= sf_prod[VW+FracBits-1:FracBits];
      sfc_q   <= sfc_prod[VW+FracBits-1:FracBits];
      p2_q    <= p_prod[VW+FracBits-1:FracBits];
      v2v_q   <= v1v_q;
      sect2_q <= sect1_q;
    end
  end

  // Stage 3: q = v*(1-s*f) and t = v*(1-s*(1-f))
  logic [2*VW-1:0] q_prod, t_prod;
  logic [VW-1:0]   q3_q, t3_q, p3_q, v3v_q;
  sector_e         sect3_q;

  always_comb begin
    q_prod = (2*VW)'(v2v_q) * (2*VW)'(OneV - sf_q);
    t_prod = (2*VW)'(v2v_q) * (2*VW)'(OneV - sfc_q);
  end

  always_ff @(posedge clk_i) begin
    if (adv3) begin
      q3_q    <= q_prod[VW+FracBits-1:FracBits];
      t3_q    <= t_prod[VW+FracBits-1:FracBits];
      p3_q    <= p2_q;
      v3v_q   <= v2v_q;
      sect3_q <= sect2_q;
    end
  end

  // Stage 4: sector mux into the output register; zero value gives zero terms
  logic [VW-1:0]   r_c, g_c, b_c;
  logic [OutW-1:0] red_q, green_q, blue_q;

  always_comb begin
    unique case (sect3_q)
      SECT_RED_YEL, SECT_WRAP: begin
        r_c = v3v_q; g_c = t3_q;  b_c = p3_q;
      end
      SECT_YEL_GRN: begin
        r_c = q3_q;  g_c = v3v_q; b_c = p3_q;
      end
      SECT_GRN_CYN: begin
        r_c = p3_q;  g_c = v3v_q; b_c = t3_q;
      end
      SECT_CYN_BLU: begin
        r_c = p3_q;  g_c = q3_q;  b_c = v3v_q;
      end
      SECT_BLU_MAG: begin
        r_c = t3_q;  g_c = p3_q;  b_c = v3v_q;
      end
      default: begin
        r_c = v3v_q; g_c = p3_q;  b_c = q3_q;
      end
    endcase
  end

  // Extend or mask to the 17-bit output field
  logic [EW-1:0] r_ext, g_ext, b_ext;
  assign r_ext = EW'(r_c);
  assign g_ext = EW'(g_c);
  assign b_ext = EW'(b_c);

  always_ff @(posedge clk_i) begin
    if (adv4) begin
      red_q   <= r_ext[OutW-1:0];
      green_q <= g_ext[OutW-1:0];
      blue_q  <= b_ext[OutW-1:0];
    end
  end

  assign out_valid_o = v4_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;

  // Input backpressure only when every stage is full and the output stalls
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (v1_q && v2_q && v3_q && out_valid_o && !out_ready_i))
    else $error("input stalled while pipeline has room");

  // Shaded terms stay between p and v
  a_term_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> (q3_q >= p3_q && t3_q >= p3_q && q3_q <= v3v_q && t3_q <= v3v_q))
    else $error("q or t outside p..v");

  // Zero value leaves all terms zero
  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && v3v_q == '0) |-> (p3_q == '0 && q3_q == '0 && t3_q == '0))
    else $error("nonzero term with zero value");

endmodule
